@@ rtl/matrix_multiply_add_defines.svh @@
// Assertion macros for matrix_multiply_add, which checks its own logic.
`ifndef MATRIX_MULTIPLY_ADD_DEFINES_SVH
`define MATRIX_MULTIPLY_ADD_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MMA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mma_pkg.sv @@
`default_nettype none

package mma_pkg;

    // Geometry of the stores.
    localparam int MAX_DIM    = 16;
    localparam int MAX_STRIDE = 4;
    localparam int MAX_XCOLS  = 4;
    localparam int VEC_ROWS   = MAX_DIM * MAX_STRIDE;

    localparam int A_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int XY_Y_BASE = VEC_ROWS * MAX_XCOLS;
    localparam int XY_DEPTH  = 2 * XY_Y_BASE;
    localparam int A_AW      = $clog2(A_DEPTH);
    localparam int XY_AW     = $clog2(XY_DEPTH);

    localparam int DIM_CW = $clog2(MAX_DIM + 1);
    localparam int STR_W  = $clog2(MAX_STRIDE + 1);
    localparam int VROW_W = $clog2(VEC_ROWS);

    // Field widths.
    localparam int MODE_W     = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 4;
    localparam int DATA_W     = 32;
    localparam int OUT_ROW_W  = 6;
    localparam int OUT_COL_W  = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Arithmetic widths.
    localparam int PROD_W  = 2 * DATA_W + 1;
    localparam int ACC_W   = 2 * DATA_W + $clog2(MAX_DIM);
    localparam int LIMBS   = (ACC_W + DATA_W - 1) / DATA_W;
    localparam int LIMB_W  = $clog2(LIMBS);
    localparam int PAD_W   = LIMBS * DATA_W;
    localparam int T_W     = ACC_W + DATA_W;
    localparam int F_W     = T_W + 2;
    localparam int Y_SHIFT = 16;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_X  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD_Y  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BETA      = 3'd5;

    // Datapath micro-operations.
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_CLR   = 3'd1;
    localparam logic [2:0] OP_MAC   = 3'd2;
    localparam logic [2:0] OP_BETA  = 3'd3;
    localparam logic [2:0] OP_ALPHA = 3'd4;
    localparam logic [2:0] OP_FIN   = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [ROW_W-1:0]         row_index;
        logic [COL_W-1:0]         col_index;
        logic signed [DATA_W-1:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic [OUT_ROW_W-1:0]     out_row;
        logic [OUT_COL_W-1:0]     out_col;
        logic signed [DATA_W-1:0] out_value;
        logic [STATUS_W-1:0]      status;
    } t_out_item;

    typedef struct packed {
        logic [2:0]        op;
        logic [LIMB_W-1:0] limb;
    } t_dp_ctl;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [DATA_W-1:0] value;
    } t_dp_res;

endpackage

`default_nettype wire

@@ rtl/mma_if.sv @@
`default_nettype none

interface mma_in_if;
    logic              valid;
    logic              ready;
    mma_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mma_out_if;
    logic               valid;
    logic               ready;
    mma_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/mma_ram.sv @@
`default_nettype none

module mma_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/mma_datapath.sv @@
`default_nettype none

module mma_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mma_pkg::t_dp_ctl                 i_ctl,
    input  logic signed [mma_pkg::DATA_W-1:0] i_a_data,
    input  logic signed [mma_pkg::DATA_W-1:0] i_xy_data,
    input  logic signed [mma_pkg::DATA_W-1:0] i_alpha,
    input  logic signed [mma_pkg::DATA_W-1:0] i_beta,
    output mma_pkg::t_dp_res                 o_res
);
    import mma_pkg::*;

    t_dp_ctl                  r_ctl1;
    t_dp_ctl                  r_ctl2;
    logic signed [DATA_W:0]   w_opa;
    logic signed [DATA_W-1:0] w_opb;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PAD_W-1:0]  w_pad;
    logic signed [T_W-1:0]    r_t;
    logic signed [PROD_W-1:0] r_by;
    logic [F_W-1:0]           w_sum;
    logic [F_W-DATA_W*2:0]    w_upper;
    logic                     w_fits;
    logic [DATA_W-1:0]        w_value;
    logic                     r_done;
    logic                     r_sat;
    logic [DATA_W-1:0]        r_value;

    // Multiply stage: operands are memory words, alpha, beta or one limb of the sum.
    assign w_pad = PAD_W'(r_acc);

    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (r_ctl1.op)
            OP_MAC: begin
                w_opa = (DATA_W + 1)'(i_a_data);
                w_opb = i_xy_data;
            end
            OP_BETA: begin
                // A zero beta leaves the y term out, so the y word is not used.
                if (i_beta != '0) begin
                    w_opa = (DATA_W + 1)'(i_xy_data);
                    w_opb = i_beta;
                end
            end
            OP_ALPHA: begin
                if (r_ctl1.limb == LIMB_W'(LIMBS - 1)) begin
                    w_opa = {w_pad[PAD_W-1], w_pad[PAD_W-1 -: DATA_W]};
                end else begin
                    w_opa = {1'b0, w_pad[r_ctl1.limb*DATA_W +: DATA_W]};
                end
                w_opb = i_alpha;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    // Final rounding and saturation.
    always_comb begin
        w_sum = F_W'(r_t) + (F_W'(r_by) << Y_SHIFT) + (F_W'(1) << (DATA_W - 1));
        w_upper = w_sum[F_W-1:2*DATA_W-1];
        w_fits = (&w_upper) || !(|w_upper);
        if (w_fits) begin
            w_value = w_sum[2*DATA_W-1:DATA_W];
        end else if (w_sum[F_W-1]) begin
            w_value = SAT_MIN;
        end else begin
            w_value = SAT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '{op: OP_NOP, limb: '0};
            r_ctl2 <= '{op: OP_NOP, limb: '0};
            r_done <= 1'b0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_done <= (r_ctl2.op == OP_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_opa * w_opb;
        case (r_ctl2.op)
            OP_CLR: begin
                r_acc <= '0;
                r_t   <= '0;
                r_by  <= '0;
            end
            OP_MAC: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            OP_BETA: begin
                r_by <= r_prod;
            end
            OP_ALPHA: begin
                r_t <= (r_t <<< DATA_W) + T_W'(r_prod);
            end
            OP_FIN: begin
                r_value <= w_value;
                r_sat   <= !w_fits;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_res = '{done: r_done, sat: r_sat, value: r_value};

endmodule

`default_nettype wire

@@ rtl/matrix_multiply_add.sv @@
// Compute item: after acceptance the sequencer runs the inner-product steps for one row of op(A),
// then the beta, alpha and finishing steps; a new item is taken only once the result is registered.
// One shared multiplier serves every step: inner-product steps, one beta step, three alpha limbs.
// Load items need no sequencer steps; an out-of-range compute goes straight to the output state.
// Synchronous active-low reset restores the register defaults; the stores are not cleared.
`default_nettype none

`include "matrix_multiply_add_defines.svh"

module matrix_multiply_add (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mma_in_if.sink                          i_in,
    mma_out_if.source                       o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mma_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mma_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mma_pkg::*;

    // Sequencer states. Every state that issues work hands one micro-operation to the
    // datapath, which registers it alongside the memory read and multiplies before it adds.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_BETA  = 3'd2;
    localparam logic [2:0] S_ALPHA = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // Configuration registers.
    logic [4:0]        r_num_rows;
    logic [4:0]        r_num_cols;
    logic              r_transpose;
    logic [2:0]        r_row_stride;
    logic [DATA_W-1:0] r_alpha;
    logic [DATA_W-1:0] r_beta;

    logic [2:0]        r_state, n_state;
    logic              r_err, n_err;
    logic [COL_W-1:0]  r_col, n_col;
    logic [VROW_W-1:0] r_prow, n_prow;
    logic [VROW_W-1:0] r_xrow, n_xrow;
    logic [A_AW-1:0]   r_aaddr, n_aaddr;
    logic [DIM_CW-1:0] r_k, n_k;
    logic [LIMB_W-1:0] r_limb, n_limb;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    t_in_item          w_item;
    logic              w_in_acc;
    logic              w_out_free;
    logic [DIM_CW-1:0] w_nr;
    logic [DIM_CW-1:0] w_nc;
    logic [DIM_CW-1:0] w_numeq;
    logic [DIM_CW-1:0] w_inner;
    logic [STR_W-1:0]  w_stride;
    logic              w_range_err;
    logic              w_a_we;
    logic [A_AW-1:0]   w_a_waddr;
    logic              w_xy_we;
    logic [XY_AW-1:0]  w_xy_waddr;
    logic [XY_AW-1:0]  w_xy_raddr;
    logic [DATA_W-1:0] w_a_rdata;
    logic [DATA_W-1:0] w_xy_rdata;
    t_dp_ctl           w_ctl;
    t_dp_res           w_res;
    t_out_item         w_result;

    assign w_item      = i_in.payload;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Sizes above the store bounds act as the bound; a stride of zero acts as one.
    always_comb begin
        w_nr = (int'(r_num_rows) > MAX_DIM) ? DIM_CW'(MAX_DIM) : DIM_CW'(r_num_rows);
        w_nc = (int'(r_num_cols) > MAX_DIM) ? DIM_CW'(MAX_DIM) : DIM_CW'(r_num_cols);
        if (r_row_stride == 3'd0) begin
            w_stride = STR_W'(1);
        end else if (int'(r_row_stride) > MAX_STRIDE) begin
            w_stride = STR_W'(MAX_STRIDE);
        end else begin
            w_stride = STR_W'(r_row_stride);
        end
        w_numeq = r_transpose ? w_nc : w_nr;
        w_inner = r_transpose ? w_nr : w_nc;
        w_range_err = (int'(w_item.row_index) >= int'(w_numeq))
                   || (int'(w_item.col_index) >= MAX_XCOLS);
    end

    // Loads write straight into the stores in the cycle they are accepted. Loads
    // outside a store are dropped. The x and y stores share one memory, y on top.
    always_comb begin
        w_a_we = w_in_acc && (w_item.mode == MODE_LOAD_A)
              && (int'(w_item.row_index) < MAX_DIM) && (int'(w_item.col_index) < MAX_DIM);
        w_a_waddr = A_AW'(int'(w_item.row_index) * MAX_DIM + int'(w_item.col_index));
        w_xy_we = w_in_acc
               && ((w_item.mode == MODE_LOAD_X) || (w_item.mode == MODE_LOAD_Y))
               && (int'(w_item.row_index) < VEC_ROWS)
               && (int'(w_item.col_index) < MAX_XCOLS);
        w_xy_waddr = XY_AW'(((w_item.mode == MODE_LOAD_Y) ? XY_Y_BASE : 0)
                   + int'(w_item.row_index) * MAX_XCOLS + int'(w_item.col_index));
        if (r_state == S_BETA) begin
            w_xy_raddr = XY_AW'(XY_Y_BASE + int'(r_prow) * MAX_XCOLS + int'(r_col));
        end else begin
            w_xy_raddr = XY_AW'(int'(r_xrow) * MAX_XCOLS + int'(r_col));
        end
    end

    mma_ram #(
        .DEPTH (A_DEPTH),
        .WIDTH (DATA_W)
    ) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_a_waddr),
        .i_wdata (w_item.data_value),
        .i_raddr (r_aaddr),
        .o_rdata (w_a_rdata)
    );

    mma_ram #(
        .DEPTH (XY_DEPTH),
        .WIDTH (DATA_W)
    ) u_xy_ram (
        .i_clk   (i_clk),
        .i_we    (w_xy_we),
        .i_waddr (w_xy_waddr),
        .i_wdata (w_item.data_value),
        .i_raddr (w_xy_raddr),
        .o_rdata (w_xy_rdata)
    );

    mma_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_a_data  (w_a_rdata),
        .i_xy_data (w_xy_rdata),
        .i_alpha   (r_alpha),
        .i_beta    (r_beta),
        .o_res     (w_res)
    );

    // The result item: an out-of-range compute reports zeros with the range status.
    always_comb begin
        if (r_err) begin
            w_result = '{out_row: '0, out_col: '0, out_value: '0, status: ST_RANGE};
        end else begin
            w_result = '{out_row:   OUT_ROW_W'(r_prow),
                         out_col:   OUT_COL_W'(r_col),
                         out_value: w_res.value,
                         status:    w_res.sat ? ST_SAT : ST_OK};
        end
    end

    // Sequencer. Idle cycles clear the accumulators, so a compute item starts from
    // zero. The multiply-accumulate steps walk a row of op(A) and a column of x with
    // running addresses; the alpha steps begin once the last product has been added,
    // which the single beta step in between guarantees.
    always_comb begin
        n_state     = r_state;
        n_err       = r_err;
        n_col       = r_col;
        n_prow      = r_prow;
        n_xrow      = r_xrow;
        n_aaddr     = r_aaddr;
        n_k         = r_k;
        n_limb      = r_limb;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        w_ctl       = '{op: OP_NOP, limb: r_limb};
        case (r_state)
            S_IDLE: begin
                w_ctl.op = OP_CLR;
                if (w_in_acc && (w_item.mode == MODE_COMPUTE)) begin
                    n_col   = w_item.col_index;
                    n_prow  = VROW_W'(int'(w_item.row_index) * int'(w_stride));
                    n_xrow  = '0;
                    n_k     = '0;
                    n_aaddr = r_transpose ? A_AW'(int'(w_item.row_index))
                                          : A_AW'(int'(w_item.row_index) * MAX_DIM);
                    n_err   = w_range_err;
                    if (w_range_err) begin
                        n_state = S_OUT;
                    end else if (w_inner == '0) begin
                        n_state = S_BETA;
                    end else begin
                        n_state = S_MAC;
                    end
                end
            end
            S_MAC: begin
                w_ctl.op = OP_MAC;
                n_aaddr  = r_aaddr + (r_transpose ? A_AW'(MAX_DIM) : A_AW'(1));
                n_xrow   = r_xrow + VROW_W'(w_stride);
                n_k      = r_k + DIM_CW'(1);
                if (int'(r_k) + 1 >= int'(w_inner)) begin
                    n_state = S_BETA;
                end
            end
            S_BETA: begin
                w_ctl.op = OP_BETA;
                n_limb   = LIMB_W'(LIMBS - 1);
                n_state  = S_ALPHA;
            end
            S_ALPHA: begin
                w_ctl.op = OP_ALPHA;
                if (r_limb == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_limb = r_limb - LIMB_W'(1);
                end
            end
            S_FIN: begin
                w_ctl.op = OP_FIN;
                n_state  = S_WAIT;
            end
            S_WAIT: begin
                if (w_res.done) begin
                    if (w_out_free) begin
                        n_out       = w_result;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out       = w_result;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_err        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_num_rows   <= 5'd16;
            r_num_cols   <= 5'd16;
            r_transpose  <= 1'b0;
            r_row_stride <= 3'd1;
            r_alpha      <= 32'h0001_0000;
            r_beta       <= '0;
        end else begin
            r_state     <= n_state;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_NUM_ROWS:  r_num_rows   <= i_cfg_data[4:0];
                    REG_NUM_COLS:  r_num_cols   <= i_cfg_data[4:0];
                    REG_TRANSPOSE: r_transpose  <= i_cfg_data[0];
                    REG_STRIDE:    r_row_stride <= i_cfg_data[2:0];
                    REG_ALPHA:     r_alpha      <= i_cfg_data;
                    REG_BETA:      r_beta       <= i_cfg_data;
                    default:       r_transpose  <= r_transpose;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col   <= n_col;
        r_prow  <= n_prow;
        r_xrow  <= n_xrow;
        r_aaddr <= n_aaddr;
        r_k     <= n_k;
        r_limb  <= n_limb;
        r_out   <= n_out;
    end

    // The datapath finishes a compute only while the sequencer waits for it.
    `MMA_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, w_res.done, r_state == S_WAIT, "result finished outside the wait state")
    // A new result appears only from the wait or output state.
    `MMA_ASSERT_IMP(a_out_source, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_WAIT || $past(r_state) == S_OUT, "result item loaded from an unexpected state")
    // Range errors carry all-zero fields.
    `MMA_ASSERT_IMP(a_range_zero, i_clk, i_rst_n, r_out_valid && (r_out.status == ST_RANGE), (r_out.out_value == '0) && (r_out.out_row == '0) && (r_out.out_col == '0), "range error result with nonzero fields")
    // The alpha steps always end with the finishing step.
    `MMA_ASSERT_NXT(a_alpha_to_fin, i_clk, i_rst_n, (r_state == S_ALPHA) && (r_limb == '0), (r_state == S_FIN) && (w_ctl.op == OP_FIN), "alpha steps did not end in the finishing step")

endmodule

`default_nettype wire
